// ----- sv/pulse_peak_pair_detector_core_macros.svh -----
// Assertion macros shared by the pulse peak pair detector RTL.
`ifndef PULSE_PEAK_PAIR_DETECTOR_CORE_MACROS_SVH
`define PULSE_PEAK_PAIR_DETECTOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/ppd_pkg.sv -----
// Shared constants and types for the pulse peak pair detector.
package ppd_pkg;

	localparam int AMP_BITS      = 12;
	localparam int INTERVAL_BITS = 16;

	localparam logic [AMP_BITS-1:0]      MIN_AMP_RESET = 12'd20;
	localparam logic [INTERVAL_BITS-1:0] INTERVAL_MAX  = 16'hFFFF;

	// Decision of the pair judge for the item in flight.
	typedef struct packed {
		logic confirm_first; // first swing completes on this item
		logic pair_ok;       // second swing matches the first: report a beat
		logic promote;       // larger second swing replaces the first, no beat
	} judge_t;

endpackage

// ----- sv/ppd_if.sv -----
// Valid/ready stream interfaces for sample items and beat result items.
interface ppd_sample_if #(
	parameter int SAMPLE_BITS = 12
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] ac_sample;

	modport source (output valid, output ac_sample, input ready);
	modport sink   (input valid, input ac_sample, output ready);
endinterface

interface ppd_beat_if
	import ppd_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic                     beat_found;
	logic [INTERVAL_BITS-1:0] beat_interval;
	logic [AMP_BITS-1:0]      swing_amplitude;

	modport source (output valid, output beat_found, output beat_interval,
		output swing_amplitude, input ready);
	modport sink   (input valid, input beat_found, input beat_interval,
		input swing_amplitude, output ready);
endinterface

// ----- sv/ppd_pair_judge.sv -----
// Swing completion and pair band checks for the pulse peak pair detector.
module ppd_pair_judge
	import ppd_pkg::*;
#(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   first_confirmed,
	input  logic                   swing_complete,
	input  logic [SAMPLE_BITS-1:0] rise,
	input  logic [SAMPLE_BITS-1:0] first_rise,
	input  logic [SAMPLE_BITS-1:0] second_rise,
	input  logic [AMP_BITS-1:0]    min_amp,
	output judge_t                 verdict
);

	localparam int CW = (SAMPLE_BITS > AMP_BITS) ? SAMPLE_BITS : AMP_BITS;

	// 2*little >= big and 4*little <= 5*big
	function automatic logic in_band(input logic [SAMPLE_BITS-1:0] big,
		input logic [SAMPLE_BITS-1:0] little);
		logic [SAMPLE_BITS+2:0] little_x4;
		logic [SAMPLE_BITS+2:0] big_x5;
		logic                   lower_ok;
		little_x4 = {1'b0, little, 2'b00};
		big_x5    = {1'b0, big, 2'b00} + {3'b000, big};
		lower_ok  = {little, 1'b0} >= {1'b0, big};
		return lower_ok && (little_x4 <= big_x5);
	endfunction

	logic [SAMPLE_BITS-1:0] largest;
	logic [SAMPLE_BITS+1:0] rise_x4;
	logic [SAMPLE_BITS+1:0] largest_x3;
	logic                   done;
	logic                   second_done;
	logic                   first_bigger;
	logic                   band_a;
	logic                   band_b;

	always_comb begin
		largest      = first_confirmed ? second_rise : first_rise;
		rise_x4      = {rise, 2'b00};
		largest_x3   = {1'b0, largest, 1'b0} + {2'b00, largest};
		// below three quarters of the largest rise, and tall enough
		done         = (rise_x4 < largest_x3) && (CW'(largest) > CW'(min_amp));
		second_done  = first_confirmed && swing_complete && done;
		first_bigger = first_rise > second_rise;
		band_a       = in_band(first_rise, second_rise);
		band_b       = in_band(second_rise, first_rise);

		verdict.confirm_first = !first_confirmed && swing_complete && done;
		verdict.pair_ok       = second_done && (first_bigger ? band_a : band_b);
		verdict.promote       = second_done && !first_bigger && !band_b;
	end

endmodule

// ----- sv/pulse_peak_pair_detector_core.sv -----
// Top level of the pulse peak pair detector.
//
// The block takes one pulse-sensor AC sample per item and returns exactly one
// result item per sample. It follows two trough-to-peak swings: the first one
// until it is confirmed (the sample drops below 3/4 of its largest rise and that
// rise is above min_amplitude), then the second one. When the second swing is
// confirmed with a rise between 0.5 and 2 times the first, the result item
// carries beat_found = 1, the number of samples between the two crests
// (modulo 2^COUNT_BITS, saturated at 65535) and the second swing's rise; the
// second swing then becomes the first. A second swing that is larger and out
// of band replaces the first without a beat. Non-beat items carry zeros.
// Throughput is one item per clock cycle while beats.ready stays high. A
// sample is held in the input register and moves into the result register
// when that one is free or being emptied. All swing tracking and threshold
// compares are done in a single combinational pass between the two registers.
// While a result waits, one more sample is taken into an empty input
// register; the input stalls once both registers hold an item. The user
// writes min_amplitude (reset 20) through cfg_wr_en / cfg_wr_data only while
// no item is in flight; the block itself does not enforce this.
`include "pulse_peak_pair_detector_core_macros.svh"

module pulse_peak_pair_detector_core
	import ppd_pkg::*;
#(
	parameter int SAMPLE_BITS = 12,
	parameter int COUNT_BITS  = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	ppd_sample_if.sink          samples,
	ppd_beat_if.source          beats,
	input  logic                cfg_wr_en,
	input  logic [AMP_BITS-1:0] cfg_wr_data
);

	// Configuration and swing state. Index 0 is the first swing, 1 the second.
	logic [AMP_BITS-1:0]    min_amp_q;
	logic [COUNT_BITS-1:0]  count_q;
	logic                   first_conf_q;
	logic [SAMPLE_BITS-1:0] trough_q [2];
	logic [SAMPLE_BITS-1:0] crest_q  [2];
	logic [SAMPLE_BITS-1:0] rise_q   [2];   // largest rise per swing
	logic [COUNT_BITS-1:0]  pos_q    [2];   // crest position per swing
	logic [1:0]             tv_q;
	logic [1:0]             cv_q;

	// Input register
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;

	// Result register
	logic                     out_valid_q;
	logic                     beat_q;
	logic [INTERVAL_BITS-1:0] interval_q;
	logic [AMP_BITS-1:0]      amp_q;

	logic advance;
	logic take_in;

	// Active swing, after tracking the sample
	logic [SAMPLE_BITS-1:0] act_trough;
	logic [SAMPLE_BITS-1:0] act_crest;
	logic [SAMPLE_BITS-1:0] act_rise;
	logic [COUNT_BITS-1:0]  act_pos;
	logic                   act_tv;
	logic                   act_cv;
	logic [SAMPLE_BITS-1:0] new_trough;
	logic [SAMPLE_BITS-1:0] new_crest;
	logic [COUNT_BITS-1:0]  new_pos;
	logic                   new_tv;
	logic                   new_cv;
	logic [SAMPLE_BITS-1:0] rise;
	logic [SAMPLE_BITS-1:0] new_largest;
	logic [SAMPLE_BITS-1:0] judge_first_rise;
	logic [SAMPLE_BITS-1:0] judge_second_rise;
	judge_t                 verdict;

	// Next state of both swings
	logic [SAMPLE_BITS-1:0] nxt_trough [2];
	logic [SAMPLE_BITS-1:0] nxt_crest  [2];
	logic [SAMPLE_BITS-1:0] nxt_rise   [2];
	logic [COUNT_BITS-1:0]  nxt_pos    [2];
	logic [1:0]             nxt_tv;
	logic [1:0]             nxt_cv;
	logic [COUNT_BITS-1:0]  crest_gap;
	logic [INTERVAL_BITS-1:0] interval;

	// Move the input register into the result register when that one is free
	// or being emptied; take a new sample when the input register is empty or moves.
	assign advance       = valid_s1 && (!out_valid_q || beats.ready);
	assign samples.ready = !valid_s1 || advance;
	assign take_in       = samples.valid && samples.ready;

	assign beats.valid           = out_valid_q;
	assign beats.beat_found      = beat_q;
	assign beats.beat_interval   = interval_q;
	assign beats.swing_amplitude = amp_q;

	// Track the trough and crest of the active swing.
	always_comb begin
		act_trough = first_conf_q ? trough_q[1] : trough_q[0];
		act_crest  = first_conf_q ? crest_q[1]  : crest_q[0];
		act_rise   = first_conf_q ? rise_q[1]   : rise_q[0];
		act_pos    = first_conf_q ? pos_q[1]    : pos_q[0];
		act_tv     = first_conf_q ? tv_q[1]     : tv_q[0];
		act_cv     = first_conf_q ? cv_q[1]     : cv_q[0];

		new_trough = act_trough;
		new_crest  = act_crest;
		new_pos    = act_pos;
		new_tv     = act_tv;
		new_cv     = act_cv;
		if (!act_tv || (sample_s1 < act_trough)) begin
			// new trough: restart the crest
			new_trough = sample_s1;
			new_tv     = 1'b1;
			new_crest  = '0;
			new_cv     = 1'b0;
		end else if (!act_cv || (sample_s1 > act_crest)) begin
			new_crest = sample_s1;
			new_cv    = 1'b1;
			new_pos   = count_q;
		end

		// Never negative: the trough is at or below the sample here.
		rise        = sample_s1 - new_trough;
		new_largest = (rise > act_rise) ? rise : act_rise;

		judge_first_rise  = first_conf_q ? rise_q[0]   : new_largest;
		judge_second_rise = first_conf_q ? new_largest : rise_q[1];
	end

	ppd_pair_judge #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_judge (
		.first_confirmed (first_conf_q),
		.swing_complete  (new_tv && new_cv),
		.rise            (rise),
		.first_rise      (judge_first_rise),
		.second_rise     (judge_second_rise),
		.min_amp         (min_amp_q),
		.verdict         (verdict)
	);

	// Write back the active swing, then shift the second into the first on a
	// beat or on a promotion.
	always_comb begin
		nxt_trough = trough_q;
		nxt_crest  = crest_q;
		nxt_rise   = rise_q;
		nxt_pos    = pos_q;
		nxt_tv     = tv_q;
		nxt_cv     = cv_q;
		if (first_conf_q) begin
			nxt_trough[1] = new_trough;
			nxt_crest[1]  = new_crest;
			nxt_rise[1]   = new_largest;
			nxt_pos[1]    = new_pos;
			nxt_tv[1]     = new_tv;
			nxt_cv[1]     = new_cv;
		end else begin
			nxt_trough[0] = new_trough;
			nxt_crest[0]  = new_crest;
			nxt_rise[0]   = new_largest;
			nxt_pos[0]    = new_pos;
			nxt_tv[0]     = new_tv;
			nxt_cv[0]     = new_cv;
		end

		// First crest is untouched while the second swing is active.
		crest_gap = new_pos - pos_q[0];
		interval  = (crest_gap > COUNT_BITS'(INTERVAL_MAX)) ? INTERVAL_MAX
			: crest_gap[INTERVAL_BITS-1:0];

		if (verdict.pair_ok || verdict.promote) begin
			nxt_trough[0] = nxt_trough[1];
			nxt_crest[0]  = nxt_crest[1];
			nxt_rise[0]   = nxt_rise[1];
			nxt_pos[0]    = nxt_pos[1];
			nxt_tv[0]     = nxt_tv[1];
			nxt_cv[0]     = nxt_cv[1];
			nxt_trough[1] = '0;
			nxt_crest[1]  = '0;
			nxt_rise[1]   = '0;
			nxt_pos[1]    = '0;
			nxt_tv[1]     = 1'b0;
			nxt_cv[1]     = 1'b0;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_amp_q <= MIN_AMP_RESET;
		end else if (cfg_wr_en) begin
			min_amp_q <= cfg_wr_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			sample_s1 <= samples.ac_sample;
		end
	end

	// Swing state, advanced once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			first_conf_q <= 1'b0;
			trough_q     <= '{default: '0};
			crest_q      <= '{default: '0};
			rise_q       <= '{default: '0};
			pos_q        <= '{default: '0};
			tv_q         <= '0;
			cv_q         <= '0;
		end else if (advance) begin
			count_q      <= count_q + COUNT_BITS'(1);
			first_conf_q <= first_conf_q || verdict.confirm_first;
			trough_q     <= nxt_trough;
			crest_q      <= nxt_crest;
			rise_q       <= nxt_rise;
			pos_q        <= nxt_pos;
			tv_q         <= nxt_tv;
			cv_q         <= nxt_cv;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (beats.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			beat_q     <= verdict.pair_ok;
			interval_q <= verdict.pair_ok ? interval : '0;
			amp_q      <= verdict.pair_ok ? AMP_BITS'(new_largest) : '0;
		end
	end

	// Checks
	`PPD_ASSERT_NOW(a_no_beat_zero, clk, arst_n, out_valid_q && !beat_q, (interval_q == '0) && (amp_q == '0), "non-beat item carries nonzero payload")
	`PPD_ASSERT_NOW(a_crest_needs_trough, clk, arst_n, cv_q != 2'b00, (cv_q & ~tv_q) == 2'b00, "crest valid without trough valid")
	`PPD_ASSERT_NOW(a_second_idle, clk, arst_n, !first_conf_q, (tv_q[1] == 1'b0) && (rise_q[1] == '0), "second swing in use before first confirmed")
	`PPD_ASSERT_NEXT(a_shift_clears, clk, arst_n, advance && (verdict.pair_ok || verdict.promote), (tv_q[1] == 1'b0) && first_conf_q, "second swing not cleared after shift")
	`PPD_ASSERT_NEXT(a_stage_holds, clk, arst_n, valid_s1 && !advance, valid_s1 && $stable(sample_s1), "input register lost an item while stalled")

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the pulse peak pair detector core.
`timescale 1ns / 100ps

module testbench;
	import ppd_pkg::*;

	localparam int SAMPLE_BITS = 12;
	localparam int COUNT_BITS  = 32;
	localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;

	// One expected result item: beat flag, crest-to-crest interval, rise.
	typedef struct packed {
		logic                     found;
		logic [INTERVAL_BITS-1:0] interval;
		logic [AMP_BITS-1:0]      amp;
	} beat_result_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [AMP_BITS-1:0] cfg_wr_data;

	ppd_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
	ppd_beat_if beat_ch ();

	pulse_peak_pair_detector_core #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (sample_ch),
		.beats      (beat_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// Shadow copy of the detector. Index 0 is the first swing, index 1 the second.
	logic [SAMPLE_BITS-1:0] trough_level [2] = '{default: '0};
	logic [SAMPLE_BITS-1:0] crest_level  [2] = '{default: '0};
	logic                   trough_seen  [2] = '{default: 1'b0};
	logic                   crest_seen   [2] = '{default: 1'b0};
	logic [COUNT_BITS-1:0]  crest_at     [2] = '{default: '0};
	logic [AMP_BITS:0]      peak_rise    [2] = '{default: '0};
	logic                   first_locked  = 1'b0;
	logic                   second_locked = 1'b0;
	logic [COUNT_BITS-1:0]  sample_tick   = '0;
	logic [AMP_BITS-1:0]    amp_floor     = MIN_AMP_RESET;

	beat_result_t expected_beats [$];

	int error_count = 0;
	int items_sent  = 0;

	// Idling controls for the sample sender and the result receiver.
	bit src_jitter    = 1'b1;
	bit sink_jitter   = 1'b1;
	int sink_hold_req = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop in case the block hangs on a handshake.
	initial begin
		#8_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s at %0t: got %0d, want %0d", what, $realtime, got, want);
		error_count++;
	endtask

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 65) return 0;
		if (roll < 93) return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	// Largest rise is past the floor and the sample has dropped below 3/4 of it.
	function automatic bit swing_closed(input int rise, input int largest);
		return (4 * rise < 3 * largest) && (largest > int'(amp_floor));
	endfunction

	// Little swing lies between half and 1.25 times the big one.
	function automatic bit within_band(input int big, input int little);
		return (2 * little >= big) && (4 * little <= 5 * big);
	endfunction

	// Move the second swing into the first slot and clear the second.
	function automatic void promote_second();
		trough_level[0] = trough_level[1];
		crest_level[0]  = crest_level[1];
		trough_seen[0]  = trough_seen[1];
		crest_seen[0]   = crest_seen[1];
		crest_at[0]     = crest_at[1];
		peak_rise[0]    = peak_rise[1];
		trough_level[1] = '0;
		crest_level[1]  = '0;
		trough_seen[1]  = 1'b0;
		crest_seen[1]   = 1'b0;
		crest_at[1]     = '0;
		peak_rise[1]    = '0;
		second_locked   = 1'b0;
	endfunction

	// Advance the shadow detector by one sample and return the result it must give.
	function automatic beat_result_t predict_beat(input logic [SAMPLE_BITS-1:0] s);
		beat_result_t res;
		int k;
		int rise_now;
		bit ok;
		logic [COUNT_BITS-1:0] span;
		res = '0;
		k = first_locked ? 1 : 0;
		if (!trough_seen[k] || s < trough_level[k]) begin
			trough_level[k] = s;
			trough_seen[k]  = 1'b1;
			crest_level[k]  = '0;
			crest_seen[k]   = 1'b0;
		end else if (!crest_seen[k] || s > crest_level[k]) begin
			crest_level[k] = s;
			crest_seen[k]  = 1'b1;
			crest_at[k]    = sample_tick;
		end
		rise_now = int'(s) - int'(trough_level[k]);
		if (rise_now > int'(peak_rise[k]))
			peak_rise[k] = rise_now[AMP_BITS:0];

		if (!first_locked && trough_seen[0] && crest_seen[0]) begin
			first_locked = swing_closed(rise_now, int'(peak_rise[0]));
		end else if (first_locked && trough_seen[1] && crest_seen[1]) begin
			ok = 1'b0;
			if (swing_closed(rise_now, int'(peak_rise[1]))) begin
				if (peak_rise[0] > peak_rise[1]) begin
					ok = within_band(int'(peak_rise[0]), int'(peak_rise[1]));
				end else if (!within_band(int'(peak_rise[1]), int'(peak_rise[0]))) begin
					promote_second();
				end else begin
					ok = 1'b1;
				end
			end
			second_locked = ok;
		end

		if (first_locked && second_locked) begin
			span         = crest_at[1] - crest_at[0];
			res.found    = 1'b1;
			res.interval = (span > COUNT_BITS'(INTERVAL_MAX)) ? INTERVAL_MAX
				: span[INTERVAL_BITS-1:0];
			res.amp      = peak_rise[1][AMP_BITS-1:0];
			promote_second();
		end
		sample_tick = sample_tick + COUNT_BITS'(1);
		return res;
	endfunction

	// Offer one sample, hold it until taken, then log what it must produce.
	task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
		int gap;
		gap = src_jitter ? pick_gap() : 0;
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid     <= 1'b1;
		sample_ch.ac_sample <= value;
		do @(posedge clk); while (sample_ch.ready !== 1'b1);
		expected_beats.push_back(predict_beat(value));
		items_sent++;
	endtask

	// Drop valid and let every outstanding result drain, plus the pipeline depth.
	task automatic wait_idle();
		sample_ch.valid <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_min_amp(input logic [AMP_BITS-1:0] value);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		amp_floor = value;
	endtask

	// Sample with an optional symmetric wobble, clipped to the ADC range.
	function automatic logic [SAMPLE_BITS-1:0] shaped(input int level, input int noise);
		int wobble;
		wobble = 0;
		if (noise > 0)
			wobble = int'($urandom_range(0, 2 * noise)) - noise;
		level = level + wobble;
		if (level < 0) return '0;
		if (level > SAMPLE_MAX) return SAMPLE_BITS'(SAMPLE_MAX);
		return level[SAMPLE_BITS-1:0];
	endfunction

	// Hand-built swings from reset: full-scale bits, a larger second swing that
	// takes over, a small one that is rejected and then grows to just over half,
	// and the 3/4 drop threshold hit on the boundary and one count past it.
	task automatic test_directed_swings();
		// all bits high, then low; first swing rises by 100 and confirms
		send_sample(12'd4095);
		send_sample(12'd0);
		send_sample(12'd100);
		send_sample(12'd0);
		// full-scale second swing, far above the band: replaces the first
		send_sample(12'd0);
		send_sample(12'd4095);
		send_sample(12'd0);
		// below half of the first: confirmed but no beat, keeps tracking
		send_sample(12'd0);
		send_sample(12'd1000);
		send_sample(12'd0);
		// grow to just over half; 1536 sits on the 3/4 line, 1535 drops below it
		send_sample(12'd2048);
		send_sample(12'd1536);
		send_sample(12'd1535);
		wait_idle();
	endtask

	// Floor compare is strict, and a second swing of exactly twice the first pairs.
	task automatic test_threshold_edges();
		set_min_amp(12'd1100);
		send_sample(12'd0);
		send_sample(12'd1100);
		send_sample(12'd0);
		send_sample(12'd1101);
		send_sample(12'd0);
		send_sample(12'd0);
		send_sample(12'd2202);
		send_sample(12'd0);
		wait_idle();
	endtask

	// Random pulse trains with random content, plus bursts of raw noise.
	task automatic run_random_phase(input int item_goal);
		int stop_at;
		int base;
		int nominal;
		int amp;
		int up;
		int down;
		int noise;
		int pick;
		stop_at = items_sent + item_goal;
		while (items_sent < stop_at) begin
			src_jitter  = ($urandom_range(0, 3) != 0);
			sink_jitter = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(3, 15))
					send_sample(SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)));
			end else begin
				base = $urandom_range(0, 3000);
				if ($urandom_range(0, 5) == 0)
					nominal = $urandom_range(8, SAMPLE_MAX - base);
				else
					nominal = $urandom_range(8, 800);
				repeat ($urandom_range(3, 8)) begin
					pick = $urandom_range(0, 9);
					if (pick == 0)
						amp = nominal * $urandom_range(2, 3);
					else if (pick == 1)
						amp = nominal / 3;
					else
						amp = nominal * $urandom_range(80, 120) / 100;
					up    = $urandom_range(1, 6);
					down  = $urandom_range(1, 8);
					noise = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 4) : 0;
					for (int i = 1; i <= up; i++)
						send_sample(shaped(base + amp * i / up, noise));
					for (int i = down - 1; i >= 0; i--)
						send_sample(shaped(base + amp * i / down, noise));
				end
			end
		end
	endtask

	// Sweep the amplitude floor through its extremes and a few values between.
	task automatic test_random_traffic();
		set_min_amp(MIN_AMP_RESET);
		run_random_phase(300);
		set_min_amp('0);
		run_random_phase(200);
		set_min_amp({AMP_BITS{1'b1}});
		run_random_phase(100);
		set_min_amp(AMP_BITS'($urandom_range(1, 150)));
		run_random_phase(300);
		set_min_amp(AMP_BITS'($urandom_range(0, SAMPLE_MAX)));
		run_random_phase(150);
		set_min_amp(12'd35);
		run_random_phase(200);
		wait_idle();
	endtask

	// Receiver stops for a long stretch while samples keep coming back to back.
	task automatic test_backpressure();
		src_jitter    = 1'b0;
		sink_jitter   = 1'b0;
		sink_hold_req = 64;
		repeat (4) begin
			for (int i = 0; i <= 4; i++)
				send_sample(shaped(500 + 150 * i, 2));
			for (int i = 3; i >= 0; i--)
				send_sample(shaped(500 + 150 * i, 2));
		end
		wait_idle();
	endtask

	// Result receiver: random stalls, or a long hold when a test asks for one.
	initial begin : sink_side
		int idle_left;
		idle_left = 0;
		beat_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (sink_hold_req > 0) begin
				idle_left     = sink_hold_req;
				sink_hold_req = 0;
			end else if (idle_left == 0 && sink_jitter) begin
				idle_left = pick_gap();
			end
			if (idle_left > 0) begin
				beat_ch.ready <= 1'b0;
				idle_left--;
			end else begin
				beat_ch.ready <= 1'b1;
			end
		end
	end

	// Compare every accepted result item with the oldest expectation.
	always @(posedge clk) begin : result_check
		beat_result_t want;
		if (beat_ch.valid === 1'b1 && beat_ch.ready === 1'b1) begin
			if (expected_beats.size() == 0) begin
				report_mismatch("result item with nothing expected",
					32'(beat_ch.beat_found), 0);
			end else begin
				want = expected_beats.pop_front();
				if (beat_ch.beat_found !== want.found)
					report_mismatch("beat_found", 32'(beat_ch.beat_found),
						32'(want.found));
				if (beat_ch.beat_interval !== want.interval)
					report_mismatch("beat_interval", 32'(beat_ch.beat_interval),
						32'(want.interval));
				if (beat_ch.swing_amplitude !== want.amp)
					report_mismatch("swing_amplitude", 32'(beat_ch.swing_amplitude),
						32'(want.amp));
			end
		end
	end

	initial begin
		// Hold every input at a known value and keep the block in reset.
		arst_n              <= 1'b0;
		cfg_wr_en           <= 1'b0;
		cfg_wr_data         <= MIN_AMP_RESET;
		sample_ch.valid     <= 1'b0;
		sample_ch.ac_sample <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_swings();
		test_threshold_edges();
		test_backpressure();
		test_random_traffic();

		// Drain with a bound, then wait out the pipeline to catch stray items.
		sample_ch.valid <= 1'b0;
		sink_jitter = 1'b0;
		repeat (5000) begin
			if (expected_beats.size() == 0) break;
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (expected_beats.size() != 0)
			report_mismatch("result items never arrived", expected_beats.size(), 0);

		if (error_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+sv
sv/ppd_pkg.sv
sv/ppd_if.sv
sv/ppd_pair_judge.sv
sv/pulse_peak_pair_detector_core.sv
tb/testbench.sv
